// ===== rtl/tcw_pkg.sv =====
// Shared types and constants of the text console cursor writer.
package tcw_pkg;

	localparam int unsigned CODE_W = 8;
	localparam int unsigned POS_W  = 11;

	localparam logic [CODE_W-1:0] CODE_NUL       = 8'h00;
	localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'h08;
	localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'h0A;
	localparam logic [CODE_W-1:0] CHAR_BLANK     = 8'h20;

	localparam logic REQ_PUT  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_RD_DATA
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic exec_put;
		logic rd_finish;
		logic clr_step;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_read;
		logic clear_needed;
		logic clr_last;
	} sts_t;

endpackage

// ===== rtl/text_console_cursor_writer_core.sv =====
// Top level of the text console cursor writer.
// A request is taken when start is high while busy is low, and its single result
// appears on the result ports for exactly one cycle with done high; the receiver
// cannot stall, so it must capture the result in that cycle. A put request is
// accepted and then executed in a state that updates the cursor and writes the
// screen memory, and done follows in the next cycle, during which a new request
// may already be accepted. A read request takes an extra state because the screen
// memory has a registered read port: the accept is followed by the memory read and
// then by the capture of the data. After reset, and after any put that runs past
// the last row, busy stays high while a sweep writes a space into every one of the
// ROWS*COLUMNS cells (2000 at the default size), one cell per cycle. The result of
// the clearing request is delivered at the start of that sweep. The cursor position
// reported is row*COLUMNS+column, truncated to eleven bits.
module text_console_cursor_writer_core #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       req_type,
	input  logic [tcw_pkg::CODE_W-1:0] char_code,
	input  logic [tcw_pkg::POS_W-1:0]  read_cell,
	output logic                       done,
	output logic [tcw_pkg::POS_W-1:0]  cursor_position,
	output logic                       write_valid,
	output logic [tcw_pkg::POS_W-1:0]  write_cell,
	output logic [tcw_pkg::CODE_W-1:0] write_char,
	output logic                       screen_cleared,
	output logic [tcw_pkg::CODE_W-1:0] read_char
);

	// Command and status bundles between the controller and the datapath.
	tcw_pkg::cmd_t cmd;
	tcw_pkg::sts_t sts;

	// The controller sequences each request and the clearing sweep.
	tcw_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	// The datapath holds the cursor, the screen memory and the result registers.
	tcw_dp #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_type       (req_type),
		.char_code      (char_code),
		.read_cell      (read_cell),
		.done           (done),
		.cursor_position(cursor_position),
		.write_valid    (write_valid),
		.write_cell     (write_cell),
		.write_char     (write_char),
		.screen_cleared (screen_cleared),
		.read_char      (read_char)
	);

endmodule

// ===== rtl/tcw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tcw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Controller state machine of the text console cursor writer.
module tcw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tcw_pkg::sts_t sts,
	output tcw_pkg::cmd_t cmd,
	output logic          busy
);

	tcw_pkg::state_t state_q;
	tcw_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tcw_pkg::ST_CLEAR: begin
				if (sts.clr_last) begin
					state_nxt = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = tcw_pkg::ST_EXEC;
				end
			end
			tcw_pkg::ST_EXEC: begin
				if (sts.is_read) begin
					state_nxt = tcw_pkg::ST_RD_DATA;
				end else if (sts.clear_needed) begin
					state_nxt = tcw_pkg::ST_CLEAR;
				end else begin
					state_nxt = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_RD_DATA: begin
				state_nxt = tcw_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = tcw_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			tcw_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			tcw_pkg::ST_IDLE: begin
				busy      = 1'b0;
				cmd.latch = start;
			end
			tcw_pkg::ST_EXEC: begin
				cmd.exec_put = !sts.is_read;
			end
			tcw_pkg::ST_RD_DATA: begin
				cmd.rd_finish = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/tcw_dp.sv =====
// Datapath of the text console cursor writer: cursor, screen memory and result registers.
module tcw_dp #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcw_pkg::cmd_t               cmd,
	output tcw_pkg::sts_t               sts,
	input  logic                        req_type,
	input  logic [tcw_pkg::CODE_W-1:0]  char_code,
	input  logic [tcw_pkg::POS_W-1:0]   read_cell,
	output logic                        done,
	output logic [tcw_pkg::POS_W-1:0]   cursor_position,
	output logic                        write_valid,
	output logic [tcw_pkg::POS_W-1:0]   write_cell,
	output logic [tcw_pkg::CODE_W-1:0]  write_char,
	output logic                        screen_cleared,
	output logic [tcw_pkg::CODE_W-1:0]  read_char
);

	localparam int unsigned CELLS = COLUMNS * ROWS;
	localparam int unsigned AW    = $clog2(CELLS);
	localparam int unsigned CW    = $clog2(COLUMNS);
	localparam int unsigned RW    = $clog2(ROWS);

	// Latched request.
	logic                       req_q;
	logic [tcw_pkg::CODE_W-1:0] code_q;
	logic [tcw_pkg::POS_W-1:0]  rcell_q;

	// Cursor, kept both as row and column and as a linear cell index.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] cell_q;

	logic [AW-1:0] clr_q;

	logic [CW-1:0]              nxt_col;
	logic [RW-1:0]              nxt_row;
	logic [AW-1:0]              nxt_cell;
	logic                       put_wr;
	logic [AW-1:0]              put_addr;
	logic [tcw_pkg::CODE_W-1:0] put_char;
	logic                       clear_need;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [tcw_pkg::CODE_W-1:0] ram_wdata;
	logic [tcw_pkg::CODE_W-1:0] ram_rdata;
	logic                       rd_in_range;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q   <= req_type;
			code_q  <= char_code;
			rcell_q <= read_cell;
		end
	end

	// Effect of a put request on the cursor.
	always_comb begin
		nxt_col    = col_q;
		nxt_row    = row_q;
		nxt_cell   = cell_q;
		put_wr     = 1'b0;
		put_addr   = cell_q;
		put_char   = code_q;
		clear_need = 1'b0;
		if (code_q == tcw_pkg::CODE_NEWLINE) begin
			if (row_q == RW'(ROWS - 1)) begin
				clear_need = 1'b1;
			end else begin
				nxt_col  = '0;
				nxt_row  = row_q + RW'(1);
				nxt_cell = cell_q - AW'(col_q) + AW'(COLUMNS);
			end
		end else if (code_q == tcw_pkg::CODE_BACKSPACE) begin
			// Step back and blank that cell, wrapping to the end of the previous row; at home stay put.
			put_wr   = 1'b1;
			put_char = tcw_pkg::CHAR_BLANK;
			if (col_q != '0) begin
				nxt_col  = col_q - CW'(1);
				nxt_cell = cell_q - AW'(1);
			end else if (row_q != '0) begin
				nxt_row  = row_q - RW'(1);
				nxt_col  = CW'(COLUMNS - 1);
				nxt_cell = cell_q - AW'(1);
			end
			put_addr = nxt_cell;
		end else if (code_q != tcw_pkg::CODE_NUL) begin
			put_wr   = 1'b1;
			nxt_cell = cell_q + AW'(1);
			if (col_q == CW'(COLUMNS - 1)) begin
				if (row_q == RW'(ROWS - 1)) begin
					clear_need = 1'b1;
				end else begin
					nxt_col = '0;
					nxt_row = row_q + RW'(1);
				end
			end else begin
				nxt_col = col_q + CW'(1);
			end
		end
	end

	assign sts.is_read      = (req_q == tcw_pkg::REQ_READ);
	assign sts.clear_needed = clear_need;
	assign sts.clr_last     = (clr_q == AW'(CELLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			cell_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.exec_put) begin
				if (clear_need) begin
					col_q  <= '0;
					row_q  <= '0;
					cell_q <= '0;
					clr_q  <= '0;
				end else begin
					col_q  <= nxt_col;
					row_q  <= nxt_row;
					cell_q <= nxt_cell;
				end
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	assign ram_we    = cmd.clr_step || (cmd.exec_put && put_wr);
	assign ram_waddr = cmd.clr_step ? clr_q : put_addr;
	assign ram_wdata = cmd.clr_step ? tcw_pkg::CHAR_BLANK : put_char;

	tcw_ram #(
		.WIDTH(tcw_pkg::CODE_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(AW'(rcell_q)),
		.rdata(ram_rdata)
	);

	assign rd_in_range = (32'(rcell_q) < 32'(CELLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.exec_put || cmd.rd_finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec_put) begin
			cursor_position <= clear_need ? '0 : tcw_pkg::POS_W'(nxt_cell);
			write_valid     <= put_wr;
			write_cell      <= put_wr ? tcw_pkg::POS_W'(put_addr) : '0;
			write_char      <= put_wr ? put_char : '0;
			screen_cleared  <= clear_need;
			read_char       <= '0;
		end else if (cmd.rd_finish) begin
			cursor_position <= tcw_pkg::POS_W'(cell_q);
			write_valid     <= 1'b0;
			write_cell      <= '0;
			write_char      <= '0;
			screen_cleared  <= 1'b0;
			read_char       <= rd_in_range ? ram_rdata : tcw_pkg::CHAR_BLANK;
		end
	end

endmodule
